[sv/ipsm_pkg.sv]
// ipsm_pkg: shared types and constants for the IPv4 subnet match table.
// No dependencies.
package ipsm_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int ADDR_W      = 32;
    localparam int PFX_W       = 6;
    localparam int IDX_W       = 4;
    localparam int ACT_W       = 2;
    localparam int S_DATA_W    = 72;
    localparam int M_DATA_W    = 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    typedef struct packed {
        logic [ADDR_W-1:0] net;
        logic [PFX_W-1:0]  pfx;
    } t_entry;

endpackage

[sv/ipsm_table.sv]
// ipsm_table: network table storage, one write port, one registered read port.
// Depends on ipsm_pkg.
module ipsm_table import ipsm_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  t_entry        i_wr_entry,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output t_entry        o_rd_entry
);

    t_entry r_mem [ENTRIES];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd;

endmodule

[sv/ipsm_match_unit.sv]
// ipsm_match_unit: builds the prefix mask and compares one entry with the query.
// Depends on ipsm_pkg.
module ipsm_match_unit import ipsm_pkg::*; (
    input  t_entry            i_entry,
    input  logic [ADDR_W-1:0] i_query,
    output logic              o_hit
);

    logic [PFX_W-1:0]  pfx_sat;
    logic [ADDR_W-1:0] mask;

    // prefix above 32 saturates to a full mask; zero gives an empty mask
    assign pfx_sat = (i_entry.pfx > PFX_W'(ADDR_W)) ? PFX_W'(ADDR_W) : i_entry.pfx;
    assign mask    = ~({ADDR_W{1'b1}} >> pfx_sat);
    assign o_hit   = ((i_query & mask) == (i_entry.net & mask));

endmodule

[sv/ipv4_subnet_match_table_core.sv]
// ipv4_subnet_match_table_core: top level, sequencer and output register.
// Depends on ipsm_pkg, ipsm_table, ipsm_match_unit.
//
//  channel | dir | tdata                                      | tuser       | tlast
//  s_axis  | in  | entry_address, entry_prefix, query_address | action      | -
//  m_axis  | out | match_index                                | found       | last
//
// Clear and append are taken while idle. A query holds s_axis_tready low until its
// final result is loaded: the shared compare unit checks one stored entry per cycle
// while the scan is not stalled, fed by the table's registered read port. Results stall
// the scan only while the output register is full. Reset is synchronous, active
// low, and empties the table.
module ipv4_subnet_match_table_core import ipsm_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [31:0] entry_address, [37:32] entry_prefix, [69:38] query_address
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // [1:0] action
    input  logic [ACT_W-1:0]    s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [3:0] match_index
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // [0] found
    output logic [0:0]          m_axis_tuser,
    output logic                m_axis_tlast
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_ptr;
    logic [IW-1:0]     r_cmp_idx;
    logic              r_dv;
    logic [IW-1:0]     r_pend_idx;
    logic              r_pend_v;
    logic [ADDR_W-1:0] r_query;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_found;
    logic              r_out_last;

    logic              s_beat;
    t_action           act;
    t_entry            wr_entry;
    t_entry            rd_entry;
    logic              wr_en;
    logic              rd_en;
    logic              hit;
    logic              hit_v;
    logic              out_free;
    logic              stall;
    logic              adv;
    logic              more;
    logic              out_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_beat        = s_axis_tvalid && s_axis_tready;
    assign act           = t_action'(s_axis_tuser);
    assign wr_entry.net  = s_axis_tdata[31:0];
    assign wr_entry.pfx  = s_axis_tdata[37:32];
    assign wr_en         = s_beat && (act == ACT_APPEND) && (r_count < CW'(ENTRIES));

    assign out_free = !r_out_valid || m_axis_tready;
    assign hit_v    = r_dv && hit;
    assign stall    = hit_v && r_pend_v && !out_free;
    assign adv      = (r_state == S_SCAN) && !stall;
    assign more     = (r_ptr < r_count);
    assign rd_en    = adv && more;
    assign out_load = (adv && hit_v && r_pend_v) || ((r_state == S_FLUSH) && out_free);

    ipsm_table #(.ENTRIES(ENTRIES)) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_count[IW-1:0]),
        .i_wr_entry (wr_entry),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_ptr[IW-1:0]),
        .o_rd_entry (rd_entry)
    );

    ipsm_match_unit u_match (
        .i_entry (rd_entry),
        .i_query (r_query),
        .o_hit   (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_dv        <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_beat) begin
                        unique case (act)
                            ACT_CLEAR: begin
                                r_count <= '0;
                            end
                            ACT_APPEND: begin
                                if (wr_en) begin
                                    r_count <= CW'(r_count + 1'b1);
                                end
                            end
                            ACT_QUERY: begin
                                r_query  <= s_axis_tdata[69:38];
                                r_ptr    <= '0;
                                r_dv     <= 1'b0;
                                r_pend_v <= 1'b0;
                                r_state  <= S_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (adv) begin
                        r_dv <= more;
                        if (more) begin
                            r_cmp_idx <= r_ptr[IW-1:0];
                            r_ptr     <= CW'(r_ptr + 1'b1);
                        end
                        if (hit_v) begin
                            if (r_pend_v) begin
                                r_out_idx   <= IDX_W'(r_pend_idx);
                                r_out_found <= 1'b1;
                                r_out_last  <= 1'b0;
                            end
                            r_pend_idx <= r_cmp_idx;
                            r_pend_v   <= 1'b1;
                        end
                        if (!r_dv && !more) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_out_idx   <= r_pend_v ? IDX_W'(r_pend_idx) : '0;
                        r_out_found <= r_pend_v;
                        r_out_last  <= 1'b1;
                        r_pend_v    <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = M_DATA_W'(r_out_idx);
    assign m_axis_tuser[0] = r_out_found;
    assign m_axis_tlast    = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count beyond table depth");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= r_count))
        else $error("scan pointer past entry count");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending match left over after query");

    a_mid_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (r_state != S_IDLE))
        else $error("non-final result while sequencer idle");

    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("no-match result malformed");
`endif

endmodule

[test/testbench.sv]
// testbench: self-checking bench for ipv4_subnet_match_table_core.
// Depends on ipsm_pkg; drives directed rows, then random clear/append/query/unused
// beats, and checks every result beat against directed or predicted subnet-match results.
module testbench;
    import ipsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH = ENTRIES_DEF;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RAND_BEATS = 150;
    localparam int QUIET_FROM = 120;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             found;
        logic             last;
    } t_match;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [ADDR_W-1:0] net;
        logic [PFX_W-1:0]  pfx;
        logic [ADDR_W-1:0] qaddr;
        logic [4:0]        reps;
        logic              typed;
        t_match            typed_res;
    } t_stim_row;

    localparam t_match NO_MATCH = '{idx: '0, found: 1'b0, last: 1'b1};
    localparam t_match ANY_RES  = '{idx: '0, found: 1'b0, last: 1'b0};

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // [31:0] entry_address, [37:32] entry_prefix, [69:38] query_address
    logic [S_DATA_W-1:0] s_axis_tdata;
    // [1:0] action
    logic [ACT_W-1:0]    s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // [3:0] match_index
    logic [M_DATA_W-1:0] m_axis_tdata;
    // [0] found
    logic [0:0]          m_axis_tuser;
    logic                m_axis_tlast;

    logic [ADDR_W-1:0] net_addr_tbl [TBL_DEPTH];
    logic [PFX_W-1:0]  net_pfx_tbl  [TBL_DEPTH];
    int                net_count;
    t_match            pending_matches [$];
    t_stim_row         dir_tbl [$];
    logic [ADDR_W-1:0] net_pool [8];
    int                n_errors;
    bit                idle_on;
    int                stall_left;
    t_match            got_res;
    t_match            want_res;

    ipv4_subnet_match_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] net_mask(logic [PFX_W-1:0] pfx);
        int p;
        p = (pfx > 32) ? 32 : int'(pfx);
        if (p == 0) begin
            return '0;
        end
        return 32'hFFFF_FFFF << (32 - p);
    endfunction

    function automatic t_stim_row row(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] net,
                                      logic [PFX_W-1:0] pfx, logic [ADDR_W-1:0] qaddr,
                                      int reps, logic typed, t_match res);
        t_stim_row r;
        r.act       = act;
        r.net       = net;
        r.pfx       = pfx;
        r.qaddr     = qaddr;
        r.reps      = 5'(reps);
        r.typed     = typed;
        r.typed_res = res;
        return r;
    endfunction

    // update the table copy and queue the match beats a query produces
    function automatic void apply_subnet_beat(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] ea,
                                              logic [PFX_W-1:0] ep, logic [ADDR_W-1:0] qa);
        logic [ADDR_W-1:0] m;
        int                last_hit;
        t_match            r;
        last_hit = -1;
        case (act)
            ACT_CLEAR: begin
                net_count = 0;
            end
            ACT_APPEND: begin
                if (net_count < TBL_DEPTH) begin
                    net_addr_tbl[net_count] = ea;
                    net_pfx_tbl[net_count]  = ep;
                    net_count++;
                end
            end
            ACT_QUERY: begin
                for (int i = 0; i < net_count; i++) begin
                    m = net_mask(net_pfx_tbl[i]);
                    if ((qa & m) == (net_addr_tbl[i] & m)) last_hit = i;
                end
                if (last_hit < 0) begin
                    pending_matches.push_back(NO_MATCH);
                end else begin
                    for (int i = 0; i <= last_hit; i++) begin
                        m = net_mask(net_pfx_tbl[i]);
                        if ((qa & m) == (net_addr_tbl[i] & m)) begin
                            r.idx   = IDX_W'(i);
                            r.found = 1'b1;
                            r.last  = (i == last_hit);
                            pending_matches.push_back(r);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_beat(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] ea,
                             logic [PFX_W-1:0] ep, logic [ADDR_W-1:0] qa,
                             logic typed, t_match typed_res);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, qa, ep, ea};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        if (typed) begin
            pending_matches.push_back(typed_res);
        end else begin
            apply_subnet_beat(act, ea, ep, qa);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res = '{idx: m_axis_tdata[IDX_W-1:0], found: m_axis_tuser[0],
                        last: m_axis_tlast};
            if (pending_matches.size() == 0) begin
                $display("%0t: unexpected beat idx %0d found %0d last %0d", $time,
                         got_res.idx, got_res.found, got_res.last);
                n_errors++;
            end else begin
                want_res = pending_matches.pop_front();
                if (got_res !== want_res) begin
                    $display({"%0t: mismatch expected idx %0d found %0d last %0d, ",
                              "actual idx %0d found %0d last %0d"},
                             $time, want_res.idx, want_res.found, want_res.last,
                             got_res.idx, got_res.found, got_res.last);
                    n_errors++;
                end
            end
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        logic [ACT_W-1:0]  act;
        logic [ADDR_W-1:0] ea;
        logic [PFX_W-1:0]  ep;
        logic [ADDR_W-1:0] qa;
        logic [ADDR_W-1:0] m;
        int                pick;
        int                k;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_CLEAR;
        m_axis_tready = 1'b0;
        n_errors      = 0;
        net_count     = 0;
        stall_left    = 0;
        idle_on       = 1'b1;
        foreach (net_pool[j]) net_pool[j] = $urandom;

        // query on empty table, unused action, prefix over 32, prefix under 8
        dir_tbl.push_back(row(ACT_QUERY,  '0, '0, 32'h0000_0000, 1, 1'b1, NO_MATCH));
        dir_tbl.push_back(row(ACT_UNUSED, '1, '1, 32'hFFFF_FFFF, 1, 1'b0, ANY_RES));
        dir_tbl.push_back(row(ACT_APPEND, 32'hFFFF_FFFF, 6'd63, '0, 1, 1'b0, ANY_RES));
        dir_tbl.push_back(row(ACT_APPEND, 32'h0000_0000, 6'd5,  '1, 1, 1'b0, ANY_RES));
        dir_tbl.push_back(row(ACT_APPEND, 32'hC0A8_0100, 6'd24, '0, 1, 1'b0, ANY_RES));
        dir_tbl.push_back(row(ACT_APPEND, 32'h8000_0000, 6'd1,  '0, 1, 1'b0, ANY_RES));
        dir_tbl.push_back(row(ACT_QUERY,  '0, '0, 32'hFFFF_FFFF, 1, 1'b0, ANY_RES));
        dir_tbl.push_back(row(ACT_QUERY,  '0, '0, 32'h0712_3456, 1, 1'b0, ANY_RES));
        dir_tbl.push_back(row(ACT_QUERY,  '0, '0, 32'hC0A8_01FE, 1, 1'b0, ANY_RES));
        dir_tbl.push_back(row(ACT_QUERY,  '1, '1, 32'h4000_0000, 1, 1'b0, ANY_RES));
        dir_tbl.push_back(row(ACT_CLEAR,  '1, '1, '1,            1, 1'b0, ANY_RES));
        dir_tbl.push_back(row(ACT_QUERY,  '0, '0, 32'hFFFF_FFFF, 1, 1'b1, NO_MATCH));
        // fill with match-all entries, one more is dropped, query hits all 16
        dir_tbl.push_back(row(ACT_APPEND, '0, 6'd0, '0, 17, 1'b0, ANY_RES));
        dir_tbl.push_back(row(ACT_QUERY,  '0, '0, 32'h5A5A_A5A5, 1, 1'b0, ANY_RES));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tbl[r]) begin
            repeat (dir_tbl[r].reps) begin
                send_beat(dir_tbl[r].act, dir_tbl[r].net, dir_tbl[r].pfx, dir_tbl[r].qaddr,
                          dir_tbl[r].typed, dir_tbl[r].typed_res);
            end
        end

        for (int n = 0; n < RAND_BEATS; n++) begin
            if (n == QUIET_FROM) idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            ea   = $urandom;
            ep   = PFX_W'($urandom_range(0, 63));
            qa   = $urandom;
            if (pick < 4) begin
                act = ACT_CLEAR;
            end else if (pick < 7) begin
                act = ACT_UNUSED;
            end else if (pick < 50) begin
                act = ACT_APPEND;
                k = $urandom_range(0, 9);
                if (k == 0) begin
                    ep = 6'd0;
                end else if (k == 1) begin
                    ep = PFX_W'($urandom_range(33, 63));
                end else begin
                    ep = PFX_W'($urandom_range(1, 32));
                end
                if ($urandom_range(0, 9) < 6) ea = net_pool[$urandom_range(0, 7)];
            end else begin
                act = ACT_QUERY;
                if (net_count > 0 && $urandom_range(0, 9) < 7) begin
                    k  = $urandom_range(0, net_count - 1);
                    m  = net_mask(net_pfx_tbl[k]);
                    qa = (net_addr_tbl[k] & m) | (qa & ~m);
                end else if ($urandom_range(0, 1) == 0) begin
                    qa = net_pool[$urandom_range(0, 7)] ^ 32'($urandom_range(0, 255));
                end
            end
            send_beat(act, ea, ep, qa, 1'b0, ANY_RES);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
